/* rtl/assert_macros.svh */
// Assertion helpers used by the RTL of the button press detector.
// Every check is sampled on clk and switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define BCPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition implies another one on the same edge.
`define BCPD_ASSERT_IMPL(label, cond, expr, msg) \
	`BCPD_ASSERT(label, (cond) |-> (expr), msg)

`endif

/* rtl/bcpd_pkg.sv */
// ----------------------------------------------------------------------------
// Button press detector package
// Shared widths, register indexes, event codes and the threshold bundle
// that the configuration block hands to the classifier.
// ----------------------------------------------------------------------------
package bcpd_pkg;

	// Field and register widths.
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned MsW     = 16;
	localparam int unsigned TimeW   = 32;
	localparam int unsigned EvW     = 3;
	localparam int unsigned ModeW   = 3;
	// A 16-bit millisecond count plus one, times 1000, fits in 26 bits.
	localparam int unsigned ThrW    = 26;
	localparam int unsigned UsPerMs = 1000;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_CLICK_WINDOW = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] CFG_REPEAT       = CfgIdxW'(2);
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = CfgIdxW'(3);

	// Register reset values in milliseconds.
	localparam logic [MsW-1:0] RST_CLICK_WINDOW = MsW'(600);
	localparam logic [MsW-1:0] RST_LONG_PRESS   = MsW'(1000);
	localparam logic [MsW-1:0] RST_REPEAT       = MsW'(1000);
	localparam logic [MsW-1:0] RST_DEBOUNCE     = MsW'(50);

	// Event codes.
	localparam logic [EvW-1:0] EV_NONE    = EvW'(0);
	localparam logic [EvW-1:0] EV_IDLE    = EvW'(1);
	localparam logic [EvW-1:0] EV_CLICK   = EvW'(2);
	localparam logic [EvW-1:0] EV_DOUBLE  = EvW'(3);
	localparam logic [EvW-1:0] EV_PRESS   = EvW'(4);
	localparam logic [EvW-1:0] EV_RELEASE = EvW'(5);

	// Thresholds in microseconds. A whole-ms elapsed time floor(d/1000)
	// exceeds T exactly when d >= (T+1)*1000, and reaches T exactly when
	// d >= T*1000, so no divider is needed per sample.
	typedef struct packed {
		logic [ThrW-1:0] click_hi;
		logic [ThrW-1:0] long_hi;
		logic [ThrW-1:0] repeat_lo;
		logic [ThrW-1:0] deb_lo;
		logic [ThrW-1:0] deb_hi;
		logic            repeat_zero;
		logic            deb_zero;
	} thr_t;

	// Scale a millisecond count (with one spare bit for the +1) to us.
	function automatic logic [ThrW-1:0] ms_to_us(input logic [MsW:0] ms);
		logic [ThrW-1:0] wide;
		wide = ThrW'(ms);
		return wide * ThrW'(UsPerMs);
	endfunction

	// Scale a register value plus one.
	function automatic logic [ThrW-1:0] ms_to_us_next(input logic [MsW-1:0] ms);
		logic [MsW:0] ext;
		ext = {1'b0, ms} + (MsW+1)'(1);
		return ms_to_us(ext);
	endfunction

endpackage

/* rtl/button_click_press_detector.sv */
// ----------------------------------------------------------------------------
// Button click, double click and long press detector
// Classifies timestamped button samples into one event per sample.
// ----------------------------------------------------------------------------
// Usage: each input request carries button_down and a free-running now_us
// timestamp (wraps at 2^32). Every request yields exactly one output request
// with event_code (none, idle, click, double click, press, release) and the
// saturating long press count press_total.
// Both data channels use valid/stall; a request moves when valid is high and
// stall is low. Timing registers are written through cfg_valid/cfg_ready
// (always ready) with cfg_index 0..3 and 16-bit cfg_data; other indexes are
// ignored. Write them only while no request is in flight.
// A sample is held in the input register, classified from it, and registered
// in the result register. Throughput is one sample per cycle while out_stall
// is low, with the mode, time stamps and counter updated in the classify stage.
// When out_stall is high the result is held and one more sample waits in
// the input register before in_stall rises.
// Reset puts the machine in up mode with zero times and count, and loads
// the register defaults 600, 1000, 1000 and 50 ms.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_click_press_detector (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          button_down,
	input  logic [bcpd_pkg::TimeW-1:0]    now_us,
	// Event channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bcpd_pkg::EvW-1:0]      event_code,
	output logic [bcpd_pkg::MsW-1:0]      press_total,
	// Configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcpd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bcpd_pkg::MsW-1:0]      cfg_data
);

	localparam logic [bcpd_pkg::ModeW-1:0] MODE_UP          = 3'd0;
	localparam logic [bcpd_pkg::ModeW-1:0] MODE_DOWN        = 3'd1;
	localparam logic [bcpd_pkg::ModeW-1:0] MODE_FIRST_UP    = 3'd2;
	localparam logic [bcpd_pkg::ModeW-1:0] MODE_SECOND_DOWN = 3'd3;
	localparam logic [bcpd_pkg::ModeW-1:0] MODE_PRESSED     = 3'd4;
	localparam logic [bcpd_pkg::ModeW-1:0] MODE_RESET       = 3'd5;

	bcpd_pkg::thr_t thr;

	logic                          valid_s1;
	logic                          down_s1;
	logic [bcpd_pkg::TimeW-1:0]    now_s1;

	logic [bcpd_pkg::ModeW-1:0]    mode_q, mode_d;
	logic [bcpd_pkg::TimeW-1:0]    start_q, start_d;
	logic [bcpd_pkg::TimeW-1:0]    stop_q, stop_d;
	logic [bcpd_pkg::MsW-1:0]      count_q, count_d;
	logic [bcpd_pkg::EvW-1:0]      ev_d;

	logic                          out_valid_q;
	logic [bcpd_pkg::EvW-1:0]      event_q;
	logic [bcpd_pkg::MsW-1:0]      total_q;

	logic                          out_free;
	logic                          advance;
	logic [bcpd_pkg::TimeW-1:0]    d_start;
	logic [bcpd_pkg::TimeW-1:0]    d_stop;
	logic                          start_lt_deb;
	logic                          start_gt_deb;
	logic                          start_gt_long;
	logic                          start_gt_click;
	logic                          stop_gt_deb;
	logic                          stop_ge_repeat;

	// Timing registers.
	bcpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	assign cfg_ready = 1'b1;

	// Handshake: the classify stage moves when the result register is free.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			down_s1 <= button_down;
			now_s1  <= now_us;
		end
	end

	// Elapsed times modulo 2^32, compared against the scaled thresholds.
	assign d_start        = now_s1 - start_q;
	assign d_stop         = now_s1 - stop_q;
	assign start_lt_deb   = d_start < bcpd_pkg::TimeW'(thr.deb_lo);
	assign start_gt_deb   = d_start >= bcpd_pkg::TimeW'(thr.deb_hi);
	assign start_gt_long  = d_start >= bcpd_pkg::TimeW'(thr.long_hi);
	assign start_gt_click = d_start >= bcpd_pkg::TimeW'(thr.click_hi);
	assign stop_gt_deb    = d_stop >= bcpd_pkg::TimeW'(thr.deb_hi);
	assign stop_ge_repeat = d_stop >= bcpd_pkg::TimeW'(thr.repeat_lo);

	// Mode machine: next state and event for the sample in the input register.
	always_comb begin
		mode_d  = mode_q;
		start_d = start_q;
		stop_d  = stop_q;
		count_d = count_q;
		ev_d    = bcpd_pkg::EV_NONE;
		unique case (mode_q)
			MODE_UP: begin
				if (down_s1) begin
					mode_d  = MODE_DOWN;
					start_d = now_s1;
				end
			end
			MODE_DOWN: begin
				if (!down_s1) begin
					if (!thr.deb_zero && start_lt_deb) begin
						// Bounced press: drop it entirely.
						mode_d  = MODE_UP;
						start_d = '0;
						stop_d  = '0;
						count_d = '0;
					end else begin
						mode_d = MODE_FIRST_UP;
						stop_d = now_s1;
					end
				end else if (start_gt_long) begin
					mode_d  = MODE_PRESSED;
					stop_d  = now_s1;
					count_d = bcpd_pkg::MsW'(1);
					ev_d    = bcpd_pkg::EV_PRESS;
				end
			end
			MODE_FIRST_UP: begin
				// The click window is checked before the level.
				if (start_gt_click) begin
					mode_d  = MODE_RESET;
					start_d = '0;
					stop_d  = '0;
					ev_d    = bcpd_pkg::EV_CLICK;
				end else if (down_s1 && (thr.deb_zero || stop_gt_deb)) begin
					mode_d  = MODE_SECOND_DOWN;
					start_d = now_s1;
				end
			end
			MODE_SECOND_DOWN: begin
				if (!down_s1 && start_gt_deb) begin
					mode_d  = MODE_RESET;
					start_d = '0;
					stop_d  = '0;
					ev_d    = bcpd_pkg::EV_DOUBLE;
				end
			end
			MODE_PRESSED: begin
				if (!down_s1) begin
					mode_d = MODE_RESET;
					stop_d = now_s1;
					ev_d   = bcpd_pkg::EV_RELEASE;
				end else if (!thr.repeat_zero && stop_ge_repeat) begin
					// Repeated press; the count saturates.
					stop_d = now_s1;
					if (count_q != '1) begin
						count_d = count_q + bcpd_pkg::MsW'(1);
					end
					ev_d = bcpd_pkg::EV_PRESS;
				end
			end
			default: begin
				// Reset mode and unused codes clear the machine.
				mode_d  = MODE_UP;
				start_d = '0;
				stop_d  = '0;
				count_d = '0;
				ev_d    = bcpd_pkg::EV_IDLE;
			end
		endcase
	end

	// Machine state, updated once per classified sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UP;
			start_q <= '0;
			stop_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			start_q <= start_d;
			stop_q  <= stop_d;
			count_q <= count_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			event_q <= ev_d;
			total_q <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = event_q;
	assign press_total = total_q;

	// A nonzero count only exists after a long press, until the next clear.
	`BCPD_ASSERT_IMPL(a_count_mode, count_q != '0, mode_q == MODE_PRESSED || mode_q == MODE_RESET, "press count outside long press modes")
	// Long pressed mode always carries at least one press.
	`BCPD_ASSERT_IMPL(a_pressed_count, mode_q == MODE_PRESSED, count_q != '0, "long press with zero count")
	// A press event always reports a nonzero count.
	`BCPD_ASSERT_IMPL(a_press_total, out_valid_q && event_q == bcpd_pkg::EV_PRESS, total_q != '0, "press event with zero count")
	// An accepted sample lands in the input register.
	`BCPD_ASSERT(a_accept_s1, (in_valid && !in_stall) |=> valid_s1, "accepted sample lost")
	// A classified sample always produces a result on the next edge.
	`BCPD_ASSERT(a_advance_out, advance |=> out_valid_q, "classified sample without result")

endmodule

/* rtl/bcpd_cfg.sv */
// ----------------------------------------------------------------------------
// Button press detector configuration registers
// Holds the four timing registers, kept already scaled to microseconds so
// that the classifier only subtracts and compares.
// ----------------------------------------------------------------------------
module bcpd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [bcpd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [bcpd_pkg::MsW-1:0]      cfg_data,
	output bcpd_pkg::thr_t                thr
);

	bcpd_pkg::thr_t thr_q;

	// Register write decode; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.click_hi    <= bcpd_pkg::ms_to_us_next(bcpd_pkg::RST_CLICK_WINDOW);
			thr_q.long_hi     <= bcpd_pkg::ms_to_us_next(bcpd_pkg::RST_LONG_PRESS);
			thr_q.repeat_lo   <= bcpd_pkg::ms_to_us({1'b0, bcpd_pkg::RST_REPEAT});
			thr_q.repeat_zero <= (bcpd_pkg::RST_REPEAT == '0);
			thr_q.deb_lo      <= bcpd_pkg::ms_to_us({1'b0, bcpd_pkg::RST_DEBOUNCE});
			thr_q.deb_hi      <= bcpd_pkg::ms_to_us_next(bcpd_pkg::RST_DEBOUNCE);
			thr_q.deb_zero    <= (bcpd_pkg::RST_DEBOUNCE == '0);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bcpd_pkg::CFG_CLICK_WINDOW: begin
					thr_q.click_hi <= bcpd_pkg::ms_to_us_next(cfg_data);
				end
				bcpd_pkg::CFG_LONG_PRESS: begin
					thr_q.long_hi <= bcpd_pkg::ms_to_us_next(cfg_data);
				end
				bcpd_pkg::CFG_REPEAT: begin
					thr_q.repeat_lo   <= bcpd_pkg::ms_to_us({1'b0, cfg_data});
					thr_q.repeat_zero <= (cfg_data == '0);
				end
				bcpd_pkg::CFG_DEBOUNCE: begin
					thr_q.deb_lo   <= bcpd_pkg::ms_to_us({1'b0, cfg_data});
					thr_q.deb_hi   <= bcpd_pkg::ms_to_us_next(cfg_data);
					thr_q.deb_zero <= (cfg_data == '0);
				end
				default: begin
				end
			endcase
		end
	end

	assign thr = thr_q;

endmodule
